FILE: src/ops_pkg.sv
// ============================================================================
// ops_pkg
// Shared constants, codes and the table access type of the odd-only sieve.
// ============================================================================
`default_nettype none

package ops_pkg;

    // Table geometry: one bit per odd number, bit k stands for 2k+1.
    localparam int MAX_LIMIT   = 1048576;
    localparam int WORD_BITS   = 64;
    localparam int TABLE_WORDS = MAX_LIMIT / 2 / WORD_BITS + 1;
    localparam int ADDR_W      = $clog2(TABLE_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);

    // Field widths of the items and the limit register.
    localparam int VAL_W      = 21;
    localparam int K_W        = VAL_W - 1;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = ((VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W   = 8;

    // Action codes carried on the input tuser.
    localparam logic ACT_BUILD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Status codes carried on the output tuser.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABOVE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE = 2'd2;

    // One cycle worth of table traffic.
    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } ops_mem_req_t;

endpackage

`default_nettype wire

FILE: src/ops_table.sv
// ============================================================================
// ops_table
// Sieve bit table: one synchronous memory with a registered read and a
// bypass that returns a word written in the same cycle it was read.
// ============================================================================
`default_nettype none

module ops_table (
    input  wire logic                           aclk,
    input  wire ops_pkg::ops_mem_req_t          req,
    output logic [ops_pkg::WORD_BITS-1:0]       rd_data
);
    import ops_pkg::*;

    logic [WORD_BITS-1:0] mem [0:TABLE_WORDS-1];

    logic [WORD_BITS-1:0] raw_reg;
    logic [WORD_BITS-1:0] byp_data_reg;
    logic                 byp_hit_reg;

    // The memory returns the old word on a same-address read and write, so
    // the freshly written word is captured beside it and takes precedence.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            raw_reg      <= mem[req.rd_addr];
            byp_hit_reg  <= req.wr_en && (req.wr_addr == req.rd_addr);
            byp_data_reg <= req.wr_data;
        end
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : raw_reg;

endmodule

`default_nettype wire

FILE: src/odd_only_prime_sieve_unit.sv
// ============================================================================
// odd_only_prime_sieve_unit
// Sieve of Eratosthenes over a bit table of odd numbers, with build and
// primality query items on one stream and one result item per input item.
// ============================================================================
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  tuser: action, tdata: value
//  m_        out        m_tvalid/m_tready  tuser: status, tdata: is_prime
//  cfg_      in         cfg_wr_en          cfg_wr_data: sieve limit
//
// A query item issues one table read on acceptance, the bit is resolved in a
// holding stage the next cycle, and the result item then moves on into the
// output register once it is free or being emptied. Queries therefore
// stream at one item per clock while the output side keeps up.
// A build item fills the table with ones, reads the bit of each odd base up
// to the square root of the limit and, for each base still marked prime,
// clears its multiples from its square upward through the single
// read-modify-write path of the table. Input is held off for the whole build.
// Reset (aresetn, synchronous, active low) clears control state, marks the
// table as not built and restores the limit to its maximum; the table memory
// itself is not cleared. A stalled output holds its item in the output
// register and one more in the holding stage before input is held off.
//
// ============================================================================
`default_nettype none

module odd_only_prime_sieve_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // Input items.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ops_pkg::S_DATA_W-1:0]     s_tdata,  // [20:0] value, rest zero
    input  wire logic                             s_tuser,  // [0] action

    // Result items.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ops_pkg::M_DATA_W-1:0]          m_tdata,  // [0] is_prime, rest zero
    output logic [ops_pkg::STATUS_W-1:0]          m_tuser,  // [1:0] status

    // Limit register.
    input  wire logic                             cfg_wr_en,
    input  wire logic [ops_pkg::VAL_W-1:0]        cfg_wr_data
);
    import ops_pkg::*;

    localparam int ST_W  = 3;
    localparam int I_W   = 10;
    localparam int P_W   = I_W + 1;
    localparam int SQ_W  = 2 * P_W;

    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_FILL  = 3'd1;
    localparam logic [ST_W-1:0] S_TEST  = 3'd2;
    localparam logic [ST_W-1:0] S_CHECK = 3'd3;
    localparam logic [ST_W-1:0] S_CLR   = 3'd4;
    localparam logic [ST_W-1:0] S_DONE  = 3'd5;

    localparam logic [VAL_W-1:0] LIMIT_MAX = VAL_W'(MAX_LIMIT);

    // Control and configuration.
    logic [ST_W-1:0]      state_reg, state_next;
    logic [VAL_W-1:0]     limit_reg;
    logic                 built_reg, built_next;
    logic [VAL_W-1:0]     built_lim_reg, built_lim_next;

    // Build walk.
    logic [VAL_W-1:0]     lim_reg, lim_next;
    logic [ADDR_W-1:0]    fill_reg, fill_next;
    logic [I_W-1:0]       i_reg, i_next;
    logic [K_W-1:0]       j_reg, j_next;

    // Clear stage: the word read last cycle is merged and written back.
    logic                 clr_v_reg, clr_v_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [BIT_W-1:0]     clr_bit_reg, clr_bit_next;

    // Holding stage ahead of the output register.
    logic                 q_valid_reg, q_valid_next;
    logic                 q_fresh_reg, q_fresh_next;
    logic                 q_need_reg, q_need_next;
    logic [BIT_W-1:0]     q_bit_reg, q_bit_next;
    logic                 q_prime_reg, q_prime_next;
    logic [STATUS_W-1:0]  q_status_reg, q_status_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic                 out_prime_reg, out_prime_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    ops_mem_req_t         mem_req;
    logic [WORD_BITS-1:0] mem_rdata;

    logic                 accept;
    logic                 q_adv;
    logic                 q_free;
    logic                 q_prime_now;
    logic [VAL_W-1:0]     in_value;
    logic [P_W-1:0]       p_val;
    logic [SQ_W-1:0]      sq_val;
    logic [K_W-1:0]       top_val;

    ops_table u_table (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rdata)
    );

    assign in_value = s_tdata[VAL_W-1:0];
    assign p_val    = {i_reg, 1'b1};
    assign sq_val   = SQ_W'(p_val) * SQ_W'(p_val);
    assign top_val  = lim_reg[VAL_W-1:1];

    // The holding stage moves on whenever the output register is free or
    // being emptied; input is taken only when that stage has room.
    assign q_adv   = q_valid_reg && (!out_valid_reg || m_tready);
    assign q_free  = !q_valid_reg || q_adv;
    assign s_tready = (state_reg == S_IDLE) && q_free;
    assign accept  = s_tvalid && s_tready;

    // A query bit is taken from the table in the first cycle of the holding
    // stage and kept in q_prime_reg while the stage waits for the output.
    assign q_prime_now = (q_need_reg && q_fresh_reg) ? mem_rdata[q_bit_reg] : q_prime_reg;

    always_comb begin
        state_next      = state_reg;
        built_next      = built_reg;
        built_lim_next  = built_lim_reg;
        lim_next        = lim_reg;
        fill_next       = fill_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        clr_v_next      = 1'b0;
        clr_addr_next   = clr_addr_reg;
        clr_bit_next    = clr_bit_reg;

        q_valid_next    = q_valid_reg;
        q_fresh_next    = 1'b0;
        q_need_next     = q_need_reg;
        q_bit_next      = q_bit_reg;
        q_prime_next    = q_prime_now;
        q_status_next   = q_status_reg;

        out_valid_next  = out_valid_reg;
        out_prime_next  = out_prime_reg;
        out_status_next = out_status_reg;

        mem_req         = '0;

        // Output register.
        if (q_adv) begin
            out_valid_next  = 1'b1;
            out_prime_next  = q_prime_now;
            out_status_next = q_status_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (q_adv) begin
            q_valid_next = 1'b0;
        end

        // Write-back of a cleared multiple read in the previous cycle.
        if (clr_v_reg) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_reg;
            mem_req.wr_data = mem_rdata & ~(WORD_BITS'(1) << clr_bit_reg);
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == ACT_BUILD) begin
                        lim_next   = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;
                        fill_next  = '0;
                        state_next = S_FILL;
                    end else begin
                        q_valid_next  = 1'b1;
                        q_fresh_next  = 1'b1;
                        q_need_next   = 1'b0;
                        q_prime_next  = 1'b0;
                        q_status_next = ST_OK;
                        q_bit_next    = in_value[BIT_W:1];
                        if (!built_reg) begin
                            q_status_next = ST_NO_TABLE;
                        end else if (in_value > built_lim_reg) begin
                            q_status_next = ST_ABOVE;
                        end else if (in_value == VAL_W'(2)) begin
                            q_prime_next = 1'b1;
                        end else if (in_value > VAL_W'(1) && in_value[0]) begin
                            q_need_next     = 1'b1;
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = in_value[VAL_W-1:BIT_W+1];
                        end
                    end
                end
            end

            S_FILL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = fill_reg;
                mem_req.wr_data = '1;
                fill_next       = fill_reg + ADDR_W'(1);
                if (fill_reg == ADDR_W'(TABLE_WORDS - 1)) begin
                    i_next     = I_W'(1);
                    state_next = S_TEST;
                end
            end

            S_TEST: begin
                // Stop once p squared passes the limit; otherwise fetch the
                // word that holds the bit of p.
                if (sq_val > SQ_W'(lim_reg)) begin
                    state_next = S_DONE;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ADDR_W'(i_reg >> BIT_W);
                    state_next      = S_CHECK;
                end
            end

            S_CHECK: begin
                if (mem_rdata[i_reg[BIT_W-1:0]]) begin
                    // p squared is odd, so its bit index is p squared over two.
                    j_next     = sq_val[K_W:1];
                    state_next = S_CLR;
                end else begin
                    i_next     = i_reg + I_W'(1);
                    state_next = S_TEST;
                end
            end

            S_CLR: begin
                if (j_reg <= top_val) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = j_reg[K_W-1:BIT_W];
                    clr_v_next      = 1'b1;
                    clr_addr_next   = j_reg[K_W-1:BIT_W];
                    clr_bit_next    = j_reg[BIT_W-1:0];
                    j_next          = j_reg + K_W'(p_val);
                end else begin
                    i_next     = i_reg + I_W'(1);
                    state_next = S_TEST;
                end
            end

            S_DONE: begin
                if (q_free) begin
                    built_next     = 1'b1;
                    built_lim_next = lim_reg;
                    q_valid_next   = 1'b1;
                    q_fresh_next   = 1'b1;
                    q_need_next    = 1'b0;
                    q_prime_next   = 1'b0;
                    q_status_next  = ST_OK;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_MAX;
            built_reg     <= 1'b0;
            built_lim_reg <= '0;
            clr_v_reg     <= 1'b0;
            q_valid_reg   <= 1'b0;
            q_fresh_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            built_lim_reg <= built_lim_next;
            clr_v_reg     <= clr_v_next;
            q_valid_reg   <= q_valid_next;
            q_fresh_reg   <= q_fresh_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lim_reg        <= lim_next;
        fill_reg       <= fill_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        clr_addr_reg   <= clr_addr_next;
        clr_bit_reg    <= clr_bit_next;
        q_need_reg     <= q_need_next;
        q_bit_reg      <= q_bit_next;
        q_prime_reg    <= q_prime_next;
        q_status_reg   <= q_status_next;
        out_prime_reg  <= out_prime_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 1){1'b0}}, out_prime_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire
